[hw/rtl/ccm_pkg.sv]
// ----------------------------------------------------------------------------
// ccm_pkg: shared types and constants for the AES-128 CCM core
// Holds the S-box, the AES round and key-schedule helpers, the queue item
// and configuration types, and the register index codes.
// ----------------------------------------------------------------------------
package ccm_pkg;

  // Tag length in bytes; only the B0 flags byte depends on it
  localparam int unsigned TagBytes = 4;
  localparam logic [7:0] FlagsB0 =
      8'h41 | 8'(((((TagBytes - 2) / 2) & 7) << 3));
  localparam logic [7:0] FlagsCtr = 8'h01;

  typedef enum logic [2:0] {
    REG_KEY_HIGH   = 3'd0,
    REG_KEY_LOW    = 3'd1,
    REG_NONCE_HIGH = 3'd2,
    REG_NONCE_LOW  = 3'd3,
    REG_AAD_BYTE   = 3'd4,
    REG_DECRYPT    = 3'd5,
    REG_MSG_LEN    = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic [31:0] received_tag;
  } item_t;

  typedef struct packed {
    logic [127:0] key;
    logic [103:0] nonce;
    logic [7:0]   aad;
    logic         decrypt;
    logic [15:0]  msg_len;
  } cfg_t;

  typedef struct packed {
    logic         start;
    logic [127:0] data;
    logic [127:0] key;
  } aes_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] result;
  } aes_rsp_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Multiply by x in GF(2^8)
  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Next round key from the previous one and the round constant
  function automatic logic [127:0] key_step(input logic [127:0] rk, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = rk[127:96];
    w1 = rk[95:64];
    w2 = rk[63:32];
    w3 = rk[31:0];
    t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  // One AES round: SubBytes, ShiftRows, MixColumns unless final, AddRoundKey
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                              input logic fin);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, x;
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        t[c*4+j] = SBOX[s[127-8*(((c+j)%4)*4+j) -: 8]];
      end
    end
    if (!fin) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[c*4];
        a1 = t[c*4+1];
        a2 = t[c*4+2];
        a3 = t[c*4+3];
        x  = a0 ^ a1 ^ a2 ^ a3;
        t[c*4]   = a0 ^ x ^ xtime(a0 ^ a1);
        t[c*4+1] = a1 ^ x ^ xtime(a1 ^ a2);
        t[c*4+2] = a2 ^ x ^ xtime(a2 ^ a3);
        t[c*4+3] = a3 ^ x ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      o[127-8*i -: 8] = t[i];
    end
    return o ^ rk;
  endfunction

endpackage

[hw/rtl/ccm_front.sv]
// ----------------------------------------------------------------------------
// ccm_front: input queue
// Two-entry queue that takes message blocks from the input channel and
// hands them to the back end, so each side can stall on its own.
// ----------------------------------------------------------------------------
module ccm_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ccm_pkg::item_t in_item_i,
  output logic           item_valid_o,
  input  logic           item_ready_i,
  output ccm_pkg::item_t item_o
);

  ccm_pkg::item_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_ready_o   = (cnt_q != 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = mem_q[rd_ptr_q];
  assign push         = in_valid_i & in_ready_o;
  assign pop          = item_valid_o & item_ready_i;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the incoming block
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

[hw/rtl/ccm_aes_core.sv]
// ----------------------------------------------------------------------------
// ccm_aes_core: iterative AES-128 encryption
// One round per cycle with on-the-fly key expansion; a load step on start,
// then ten rounds, after which done is raised with the result.
// ----------------------------------------------------------------------------
module ccm_aes_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ccm_pkg::aes_req_t req_i,
  output ccm_pkg::aes_rsp_t rsp_o
);

  logic [127:0] st_q, st_d;
  logic [127:0] rk_q, rk_d;
  logic [7:0]   rc_q, rc_d;
  logic [3:0]   rnd_q, rnd_d;
  logic         run_q, run_d;
  logic         done_q, done_d;
  logic [127:0] rk_next;

  assign rk_next = ccm_pkg::key_step(rk_q, rc_q);

  // Load on start, then run one round per cycle
  always_comb begin
    st_d   = st_q;
    rk_d   = rk_q;
    rc_d   = rc_q;
    rnd_d  = rnd_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (req_i.start && !run_q) begin
      st_d  = req_i.data ^ req_i.key;
      rk_d  = req_i.key;
      rc_d  = 8'h01;
      rnd_d = 4'd1;
      run_d = 1'b1;
    end else if (run_q) begin
      st_d  = ccm_pkg::aes_round(st_q, rk_next, rnd_q == 4'd10);
      rk_d  = rk_next;
      rc_d  = ccm_pkg::xtime(rc_q);
      rnd_d = rnd_q + 4'd1;
      if (rnd_q == 4'd10) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= 4'd0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      rnd_q  <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    rk_q <= rk_d;
    rc_q <= rc_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = st_q;

endmodule

[hw/rtl/ccm_back.sv]
// ----------------------------------------------------------------------------
// ccm_back: CCM sequencer and output register
// Runs the message-start passes (B0, B1, S0), the CTR keystream and the CBC-MAC
// update on the shared AES core, then loads the result register.
// ----------------------------------------------------------------------------
module ccm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ccm_pkg::cfg_t     cfg_i,
  input  logic              item_valid_i,
  output logic              item_ready_o,
  input  ccm_pkg::item_t    item_i,
  output ccm_pkg::aes_req_t aes_req_o,
  input  ccm_pkg::aes_rsp_t aes_rsp_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [63:0]       text_high_o,
  output logic [63:0]       text_low_o,
  output logic [31:0]       tag_out_o,
  output logic [63:0]       mac_high_o,
  output logic [63:0]       mac_low_o,
  output logic              mac_ok_o,
  output logic              last_block_o
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_B0   = 7'b0000010,
    ST_B1   = 7'b0000100,
    ST_S0   = 7'b0001000,
    ST_CTR  = 7'b0010000,
    ST_MAC  = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_e;

  state_e       state_q, state_d;
  logic         run_q, run_d;
  logic         started_q, started_d;
  logic [15:0]  left_q, left_d;
  logic [15:0]  ctr_q, ctr_d;
  logic [4:0]   used_q, used_d;
  logic [127:0] mac_q, mac_d;
  logic [31:0]  mask_q, mask_d;
  logic [127:0] blk_q, blk_d;
  logic [31:0]  rtag_q, rtag_d;
  logic [127:0] txt_q, txt_d;
  logic         ovalid_q, ovalid_d;
  logic [63:0]  o_th_q, o_tl_q, o_mh_q, o_ml_q;
  logic [31:0]  o_tag_q;
  logic         o_ok_q, o_last_q;
  logic         load_out;

  logic [4:0]   used;
  logic [127:0] bmask, txt, pt;
  logic [31:0]  tag;
  logic         last, op_state;

  assign used = (left_q < 16'd16) ? left_q[4:0] : 5'd16;

  // Byte mask for the valid part of the block
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      bmask[127-8*i -: 8] = (5'(i) < used_q) ? 8'hff : 8'h00;
    end
  end

  assign txt  = (blk_q ^ aes_rsp_i.result) & bmask;
  assign pt   = cfg_i.decrypt ? txt : (blk_q & bmask);
  assign tag  = mac_q[127:96] ^ mask_q;
  assign last = (left_q == {11'd0, used_q});

  assign item_ready_o = (state_q == ST_IDLE);
  assign op_state     = (state_q == ST_B0) || (state_q == ST_B1) || (state_q == ST_S0) ||
                        (state_q == ST_CTR) || (state_q == ST_MAC);

  // Select the AES input for the current pass
  always_comb begin
    aes_req_o.key   = cfg_i.key;
    aes_req_o.start = op_state && !run_q && !((state_q == ST_CTR) && (used == 5'd0));
    case (state_q)
      ST_B0:   aes_req_o.data = {ccm_pkg::FlagsB0, cfg_i.nonce, left_q};
      ST_S0:   aes_req_o.data = {ccm_pkg::FlagsCtr, cfg_i.nonce, 16'd0};
      ST_CTR:  aes_req_o.data = {ccm_pkg::FlagsCtr, cfg_i.nonce, ctr_q + 16'd1};
      default: aes_req_o.data = mac_q;
    endcase
  end

  // Sequence the passes for one block
  always_comb begin
    state_d   = state_q;
    run_d     = run_q;
    started_d = started_q;
    left_d    = left_q;
    ctr_d     = ctr_q;
    used_d    = used_q;
    mac_d     = mac_q;
    mask_d    = mask_q;
    blk_d     = blk_q;
    rtag_d    = rtag_q;
    txt_d     = txt_q;
    load_out  = 1'b0;
    if (aes_req_o.start) begin
      run_d = 1'b1;
    end
    if (aes_rsp_i.done) begin
      run_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          blk_d  = {item_i.block_high, item_i.block_low};
          rtag_d = item_i.received_tag;
          if (!started_q) begin
            started_d = 1'b1;
            left_d    = cfg_i.msg_len;
            ctr_d     = 16'd0;
            state_d   = ST_B0;
          end else begin
            state_d = ST_CTR;
          end
        end
      end
      ST_B0: begin
        if (aes_rsp_i.done) begin
          mac_d   = aes_rsp_i.result ^ {8'h00, 8'h01, cfg_i.aad, 104'd0};
          state_d = ST_B1;
        end
      end
      ST_B1: begin
        if (aes_rsp_i.done) begin
          mac_d   = aes_rsp_i.result;
          state_d = ST_S0;
        end
      end
      ST_S0: begin
        if (aes_rsp_i.done) begin
          mask_d  = aes_rsp_i.result[127:96];
          state_d = ST_CTR;
        end
      end
      ST_CTR: begin
        used_d = used;
        if (used == 5'd0) begin
          ctr_d   = ctr_q + 16'd1;
          txt_d   = '0;
          state_d = ST_FIN;
        end else if (aes_rsp_i.done) begin
          ctr_d   = ctr_q + 16'd1;
          txt_d   = txt;
          mac_d   = mac_q ^ pt;
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        if (aes_rsp_i.done) begin
          mac_d   = aes_rsp_i.result;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!ovalid_q || out_ready_i) begin
          load_out  = 1'b1;
          left_d    = left_q - {11'd0, used_q};
          started_d = !last;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign ovalid_d = load_out | (ovalid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      run_q     <= 1'b0;
      started_q <= 1'b0;
      left_q    <= 16'd0;
      ctr_q     <= 16'd0;
      mac_q     <= '0;
      mask_q    <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      run_q     <= run_d;
      started_q <= started_d;
      left_q    <= left_d;
      ctr_q     <= ctr_d;
      mac_q     <= mac_d;
      mask_q    <= mask_d;
      ovalid_q  <= ovalid_d;
    end
  end

  // Hold block data and the result register
  always_ff @(posedge clk_i) begin
    used_q <= used_d;
    blk_q  <= blk_d;
    rtag_q <= rtag_d;
    txt_q  <= txt_d;
    if (load_out) begin
      o_th_q   <= txt_q[127:64];
      o_tl_q   <= txt_q[63:0];
      o_tag_q  <= last ? tag : 32'd0;
      o_mh_q   <= last ? mac_q[127:64] : 64'd0;
      o_ml_q   <= last ? mac_q[63:0] : 64'd0;
      o_ok_q   <= cfg_i.decrypt ? (last && (tag == rtag_q)) : 1'b1;
      o_last_q <= last;
    end
  end

  assign out_valid_o  = ovalid_q;
  assign text_high_o  = o_th_q;
  assign text_low_o   = o_tl_q;
  assign tag_out_o    = o_tag_q;
  assign mac_high_o   = o_mh_q;
  assign mac_low_o    = o_ml_q;
  assign mac_ok_o     = o_ok_q;
  assign last_block_o = o_last_q;

endmodule

[hw/rtl/ccm_aes128_encrypt_decrypt_core.sv]
// ----------------------------------------------------------------------------
// ccm_aes128_encrypt_decrypt_core: AES-128 CCM block engine
// Register file, input queue, sequencer and shared AES round unit.
// ----------------------------------------------------------------------------
// Each input transfer is one 16-byte message block; each output transfer is
// the CTR output for it, with tag, full MAC and match flag on the last block.
// All AES work runs on one iterated round unit: a continuing block takes
// two passes (keystream and MAC update) between the accept state and the
// result state; the first block of a message takes three more passes (B0,
// B1 and S0) first. A two-entry input queue and the output register let the
// next block be taken while a result still waits. Write configuration only
// while the block is idle.
module ccm_aes128_encrypt_decrypt_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  input  logic [31:0] received_tag_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] text_high_o,
  output logic [63:0] text_low_o,
  output logic [31:0] tag_out_o,
  output logic [63:0] mac_high_o,
  output logic [63:0] mac_low_o,
  output logic        mac_ok_o,
  output logic        last_block_o
);

  ccm_pkg::cfg_t     cfg_q;
  ccm_pkg::item_t    in_item, q_item;
  ccm_pkg::aes_req_t aes_req;
  ccm_pkg::aes_rsp_t aes_rsp;
  logic              q_valid, q_ready;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{key: '0, nonce: '0, aad: '0, decrypt: 1'b0, msg_len: 16'd1};
    end else if (cfg_valid_i) begin
      case (ccm_pkg::cfg_reg_e'(cfg_index_i))
        ccm_pkg::REG_KEY_HIGH:   cfg_q.key[127:64]  <= cfg_data_i;
        ccm_pkg::REG_KEY_LOW:    cfg_q.key[63:0]    <= cfg_data_i;
        ccm_pkg::REG_NONCE_HIGH: cfg_q.nonce[103:64] <= cfg_data_i[39:0];
        ccm_pkg::REG_NONCE_LOW:  cfg_q.nonce[63:0]  <= cfg_data_i;
        ccm_pkg::REG_AAD_BYTE:   cfg_q.aad          <= cfg_data_i[7:0];
        ccm_pkg::REG_DECRYPT:    cfg_q.decrypt      <= cfg_data_i[0];
        ccm_pkg::REG_MSG_LEN:    cfg_q.msg_len      <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign in_item.block_high   = block_high_i;
  assign in_item.block_low    = block_low_i;
  assign in_item.received_tag = received_tag_i;

  ccm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item),
    .item_valid_o (q_valid),
    .item_ready_i (q_ready),
    .item_o       (q_item)
  );

  ccm_aes_core u_aes (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (aes_req),
    .rsp_o  (aes_rsp)
  );

  ccm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .item_i       (q_item),
    .aes_req_o    (aes_req),
    .aes_rsp_i    (aes_rsp),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .text_high_o  (text_high_o),
    .text_low_o   (text_low_o),
    .tag_out_o    (tag_out_o),
    .mac_high_o   (mac_high_o),
    .mac_low_o    (mac_low_o),
    .mac_ok_o     (mac_ok_o),
    .last_block_o (last_block_o)
  );

  // Tag and MAC appear only on the block that ends a message
  a_tag_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_block_o) |-> (tag_out_o == 32'd0 && mac_high_o == 64'd0 &&
                                        mac_low_o == 64'd0))
    else $error("tag or MAC on a block that is not last");

  // The input queue fills only through a transfer
  a_queue_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i))
    else $error("input queue filled without a transfer");

  // The AES unit is started only while the sequencer is not idle
  a_aes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    aes_req.start |-> !q_ready)
    else $error("AES pass started while idle");

endmodule

[tb/sv/tb_ccm_aes128_encrypt_decrypt_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ccm_aes128_encrypt_decrypt_core: self-checking bench for the CCM core
// Builds whole CCM messages under a series of register settings and predicts
// every output transfer with a bench-side AES-128/CCM model. A clocked
// driver and monitor apply random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_ccm_aes128_encrypt_decrypt_core;

  localparam int unsigned NumItems   = 1650;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned DrainWait  = 100;
  localparam int unsigned HoldOffAt  = 200;
  localparam int unsigned HoldOffLen = 600;

  typedef struct packed {
    logic [63:0] text_high;
    logic [63:0] text_low;
    logic [31:0] tag_out;
    logic [63:0] mac_high;
    logic [63:0] mac_low;
    logic        mac_ok;
    logic        last_block;
  } ccm_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  ccm_pkg::cfg_reg_e cfg_index_i;
  logic [63:0]       cfg_data_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [63:0]       block_high_i;
  logic [63:0]       block_low_i;
  logic [31:0]       received_tag_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [63:0]       text_high_o;
  logic [63:0]       text_low_o;
  logic [31:0]       tag_out_o;
  logic [63:0]       mac_high_o;
  logic [63:0]       mac_low_o;
  logic              mac_ok_o;
  logic              last_block_o;

  ccm_aes128_encrypt_decrypt_core uut (.*);

  // Model copy of the registers and of the message state
  logic [127:0] m_key;
  logic [39:0]  m_nonce_high;
  logic [63:0]  m_nonce_low;
  logic [7:0]   m_aad;
  logic         m_decrypt;
  logic [15:0]  m_len;
  logic [127:0] m_mac;
  logic [15:0]  m_ctr;
  logic [15:0]  m_left;
  logic [31:0]  m_mask;
  logic         m_started;

  ccm_pkg::item_t block_queue[$];
  ccm_result_t    expected_results[$];
  int unsigned    errors;
  int unsigned    cycles;
  int unsigned    result_count;
  bit             drv_calm;
  bit             mon_calm;

  // Clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [7:0] gmul2(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Plain AES-128 block encryption, byte 0 in the top bits
  function automatic logic [127:0] aes128(logic [127:0] key, logic [127:0] pt);
    logic [7:0]  st[16];
    logic [7:0]  sb[16];
    logic [7:0]  rk[16];
    logic [7:0]  rcon;
    logic [7:0]  a0, a1, a2, a3, x;
    logic [7:0]  t0, t1, t2, t3;
    logic [127:0] o;
    rcon = 8'h01;
    for (int i = 0; i < 16; i++) begin
      rk[i] = key[127-8*i -: 8];
      st[i] = pt[127-8*i -: 8] ^ rk[i];
    end
    for (int r = 1; r <= 10; r++) begin
      // next round key
      t0 = ccm_pkg::SBOX[rk[13]] ^ rcon;
      t1 = ccm_pkg::SBOX[rk[14]];
      t2 = ccm_pkg::SBOX[rk[15]];
      t3 = ccm_pkg::SBOX[rk[12]];
      rcon = gmul2(rcon);
      rk[0] ^= t0; rk[1] ^= t1; rk[2] ^= t2; rk[3] ^= t3;
      for (int i = 4; i < 16; i++) rk[i] ^= rk[i-4];
      // sub bytes and shift rows
      for (int c = 0; c < 4; c++)
        for (int j = 0; j < 4; j++)
          sb[c*4+j] = ccm_pkg::SBOX[st[((c+j)%4)*4+j]];
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = sb[c*4]; a1 = sb[c*4+1]; a2 = sb[c*4+2]; a3 = sb[c*4+3];
          x  = a0 ^ a1 ^ a2 ^ a3;
          sb[c*4]   = a0 ^ x ^ gmul2(a0 ^ a1);
          sb[c*4+1] = a1 ^ x ^ gmul2(a1 ^ a2);
          sb[c*4+2] = a2 ^ x ^ gmul2(a2 ^ a3);
          sb[c*4+3] = a3 ^ x ^ gmul2(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] = sb[i] ^ rk[i];
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = st[i];
    return o;
  endfunction

  function automatic logic [127:0] ctr_block(logic [7:0] flags, logic [15:0] v);
    return {flags, m_nonce_high, m_nonce_low, v};
  endfunction

  // Advance the CCM state by one block and return the expected transfer
  function automatic ccm_result_t ccm_block_result(ccm_pkg::item_t it);
    ccm_result_t  res;
    logic [127:0] ks, txt, pt, keep;
    logic [15:0]  used;
    logic [31:0]  tag;
    if (!m_started) begin
      m_mac     = aes128(m_key, ctr_block(ccm_pkg::FlagsB0, m_len));
      m_mac     = aes128(m_key, m_mac ^ {8'h00, 8'h01, m_aad, 104'h0});
      ks        = aes128(m_key, ctr_block(ccm_pkg::FlagsCtr, 16'h0));
      m_mask    = ks[127:96];
      m_left    = m_len;
      m_ctr     = '0;
      m_started = 1'b1;
    end
    used  = (m_left < 16) ? m_left : 16'd16;
    m_ctr = m_ctr + 16'd1;
    ks    = aes128(m_key, ctr_block(ccm_pkg::FlagsCtr, m_ctr));
    keep  = '0;
    for (int i = 0; i < 16; i++)
      if (i < used) keep[127-8*i -: 8] = 8'hff;
    txt = ({it.block_high, it.block_low} ^ ks) & keep;
    pt  = m_decrypt ? txt : ({it.block_high, it.block_low} & keep);
    if (used > 0) m_mac = aes128(m_key, m_mac ^ pt);
    m_left = m_left - used;
    res = '0;
    {res.text_high, res.text_low} = txt;
    res.mac_ok = !m_decrypt;
    if (m_left == 0) begin
      tag = m_mac[127:96] ^ m_mask;
      res.tag_out    = tag;
      {res.mac_high, res.mac_low} = m_mac;
      res.mac_ok     = m_decrypt ? (tag == it.received_tag) : 1'b1;
      res.last_block = 1'b1;
      m_started      = 1'b0;
    end
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Register write through the configuration channel, mirrored in the model
  task automatic write_reg(ccm_pkg::cfg_reg_e idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      ccm_pkg::REG_KEY_HIGH:   m_key[127:64] = val;
      ccm_pkg::REG_KEY_LOW:    m_key[63:0]   = val;
      ccm_pkg::REG_NONCE_HIGH: m_nonce_high  = val[39:0];
      ccm_pkg::REG_NONCE_LOW:  m_nonce_low   = val;
      ccm_pkg::REG_AAD_BYTE:   m_aad         = val[7:0];
      ccm_pkg::REG_DECRYPT:    m_decrypt     = val[0];
      ccm_pkg::REG_MSG_LEN:    m_len         = val[15:0];
      default: ;
    endcase
  endtask

  // Queue one whole message; kind 0 random, 1 all zeros, 2 all ones
  task automatic queue_message(int kind, int tag_hits);
    ccm_pkg::item_t it;
    ccm_result_t    res;
    bit             last;
    last = 1'b0;
    while (!last) begin
      case (kind)
        1:       it = '0;
        2:       it = '1;
        default: it = {rand64(), rand64(), 32'($urandom)};
      endcase
      // peek at the tag so that decrypt checks can be made to match
      if (m_left <= 16 && (m_started || m_len <= 16) && tag_hits != 0) begin
        automatic logic [127:0] sv_mac = m_mac;
        automatic logic [15:0]  sv_ctr = m_ctr, sv_left = m_left;
        automatic logic [31:0]  sv_mask = m_mask;
        automatic logic         sv_st = m_started;
        res = ccm_block_result(it);
        it.received_tag = res.tag_out;
        m_mac = sv_mac; m_ctr = sv_ctr; m_left = sv_left; m_mask = sv_mask;
        m_started = sv_st;
      end
      res  = ccm_block_result(it);
      last = res.last_block;
      block_queue.push_back(it);
      expected_results.push_back(res);
    end
  endtask

  // Wait until every expected transfer has arrived, then let the core settle
  task automatic wait_idle();
    while (block_queue.size() != 0 || expected_results.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 16'd0;
    if (r < 70) return 16'($urandom_range(1, 48));
    if (r < 92) return 16'($urandom_range(49, 200));
    return 16'($urandom_range(201, 600));
  endfunction

  // Stimulus sequence
  initial begin
    int unsigned sent;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = ccm_pkg::REG_KEY_HIGH;
    cfg_data_i     = '0;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    errors         = 0;
    m_key = '0; m_nonce_high = '0; m_nonce_low = '0; m_aad = '0;
    m_decrypt = 1'b0; m_len = 16'd1;
    m_mac = '0; m_ctr = '0; m_left = '0; m_mask = '0; m_started = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);

    // Reset settings, one-byte message
    queue_message(0, 0);
    wait_idle();
    // Extremes of key, nonce and associated data; length written at its maximum, then one full block
    write_reg(ccm_pkg::REG_KEY_HIGH, '1);
    write_reg(ccm_pkg::REG_KEY_LOW, '1);
    write_reg(ccm_pkg::REG_NONCE_HIGH, 64'hff_ffff_ffff);
    write_reg(ccm_pkg::REG_NONCE_LOW, '1);
    write_reg(ccm_pkg::REG_AAD_BYTE, 64'hff);
    write_reg(ccm_pkg::REG_MSG_LEN, 64'hffff);
    write_reg(ccm_pkg::REG_MSG_LEN, 64'd16);
    queue_message(2, 0);
    queue_message(1, 0);
    wait_idle();
    // Empty payload, then partial and multi-block messages
    write_reg(ccm_pkg::REG_MSG_LEN, 64'd0);
    queue_message(0, 0);
    wait_idle();
    write_reg(ccm_pkg::REG_MSG_LEN, 64'd17);
    queue_message(2, 0);
    wait_idle();
    write_reg(ccm_pkg::REG_MSG_LEN, 64'd15);
    queue_message(0, 0);
    wait_idle();
    // Decrypt with matching and mismatching tags, empty payload too
    write_reg(ccm_pkg::REG_DECRYPT, 64'd1);
    write_reg(ccm_pkg::REG_AAD_BYTE, 64'h00);
    write_reg(ccm_pkg::REG_MSG_LEN, 64'd33);
    queue_message(0, 1);
    queue_message(0, 0);
    wait_idle();
    write_reg(ccm_pkg::REG_MSG_LEN, 64'd0);
    queue_message(0, 1);
    queue_message(1, 0);
    wait_idle();

    // Random phases of whole messages
    drv_calm = 1'b0;
    sent = 0;
    while (sent < NumItems) begin
      if ($urandom_range(0, 2) == 0) begin
        write_reg(ccm_pkg::REG_KEY_HIGH, rand64());
        write_reg(ccm_pkg::REG_KEY_LOW, rand64());
      end
      if ($urandom_range(0, 1) == 0) begin
        write_reg(ccm_pkg::REG_NONCE_HIGH, rand64());
        write_reg(ccm_pkg::REG_NONCE_LOW, rand64());
      end
      write_reg(ccm_pkg::REG_AAD_BYTE, 64'($urandom_range(0, 255)));
      write_reg(ccm_pkg::REG_DECRYPT, 64'($urandom_range(0, 1)));
      repeat ($urandom_range(1, 4)) begin
        write_reg(ccm_pkg::REG_MSG_LEN, 64'(pick_len()));
        sent += (m_len == 0) ? 1 : (m_len + 15) / 16;
        queue_message($urandom_range(0, 9) == 0 ? 2 : 0, $urandom_range(0, 1));
        wait_idle();
      end
    end
    wait_idle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Driver: offer queued blocks with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned    gap;
    ccm_pkg::item_t it;
    bit             busy;
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      block_high_i   <= '0;
      block_low_i    <= '0;
      received_tag_i <= '0;
      gap = 0;
    end else begin
      busy = in_valid_i && !in_ready_o;
      if (!busy) begin
        if (gap > 0) begin
          gap--;
          in_valid_i <= 1'b0;
        end else if (block_queue.size() != 0) begin
          it = block_queue.pop_front();
          in_valid_i     <= 1'b1;
          block_high_i   <= it.block_high;
          block_low_i    <= it.block_low;
          received_tag_i <= it.received_tag;
          // switch between gapped and back-to-back stretches
          if ($urandom_range(0, 63) == 0) drv_calm = !drv_calm;
          gap = drv_calm ? 0 : $urandom_range(0, 10);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: random stalls, one long hold-off, check each transfer
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned stall;
    bit          held;
    ccm_result_t exp_r;
    if (!rst_ni) begin
      out_ready_i  <= 1'b0;
      stall        = 0;
      held         = 1'b0;
      result_count = 0;
      mon_calm     = 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        result_count++;
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer");
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (text_high_o !== exp_r.text_high) begin
            $error("text_high exp %h got %h", exp_r.text_high, text_high_o); errors++;
          end
          if (text_low_o !== exp_r.text_low) begin
            $error("text_low exp %h got %h", exp_r.text_low, text_low_o); errors++;
          end
          if (tag_out_o !== exp_r.tag_out) begin
            $error("tag_out exp %h got %h", exp_r.tag_out, tag_out_o); errors++;
          end
          if (mac_high_o !== exp_r.mac_high) begin
            $error("mac_high exp %h got %h", exp_r.mac_high, mac_high_o); errors++;
          end
          if (mac_low_o !== exp_r.mac_low) begin
            $error("mac_low exp %h got %h", exp_r.mac_low, mac_low_o); errors++;
          end
          if (mac_ok_o !== exp_r.mac_ok) begin
            $error("mac_ok exp %b got %b", exp_r.mac_ok, mac_ok_o); errors++;
          end
          if (last_block_o !== exp_r.last_block) begin
            $error("last_block exp %b got %b", exp_r.last_block, last_block_o); errors++;
          end
        end
        if ($urandom_range(0, 63) == 0) mon_calm = !mon_calm;
        stall = mon_calm ? 0 : $urandom_range(0, 10);
        // hold off once, while enough blocks are pending to back up the input
        if (!held && result_count >= HoldOffAt && block_queue.size() > 4) begin
          stall = HoldOffLen;
          held  = 1'b1;
        end
      end
      if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial cycles = 0;

endmodule
